// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WFMS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WFMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/wfms_pkg.sv =====
// ----------------------------------------------------------------------------
// wfms_pkg
// Types, constants and register codes of the wall-follow mode selector.
// ----------------------------------------------------------------------------
package wfms_pkg;

  // scan geometry
  localparam int MAX_SAMPLES = 1024;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);

  localparam logic [IDX_W-1:0] RIGHT_END      = IDX_W'(200);
  localparam logic [IDX_W-1:0] DIAG_RIGHT_END = IDX_W'(310);
  localparam logic [IDX_W-1:0] FRONT_END      = IDX_W'(420);
  localparam logic [IDX_W-1:0] DIAG_LEFT_END  = IDX_W'(530);
  localparam logic [IDX_W-1:0] LAST_IDX       = IDX_W'(MAX_SAMPLES - 1);

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DETECT_DIST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LINEAR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ANGULAR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXECUTING    = 3'd5;

  typedef enum logic [1:0] {
    MODE_FIND      = 2'd0,
    MODE_TURN_LEFT = 2'd1,
    MODE_FOLLOW    = 2'd2,
    MODE_TURN_ONLY = 2'd3
  } drive_mode_t;

  typedef struct packed {
    logic [13:0] detect_dist_mm;
    logic [15:0] max_range_mm;
    logic [10:0] base_linear_vel;
    logic [10:0] base_angular_vel;
    logic [7:0]  lost_limit;
    logic        executing;
  } cfg_t;

  // one range sample entering the region stage
  typedef struct packed {
    logic        fire;
    logic        last;
    logic [15:0] value;
  } sample_req_t;

  // region minima including the sample in flight
  typedef struct packed {
    logic [15:0] right;
    logic [15:0] diag_right;
    logic [15:0] front;
    logic [15:0] diag_left;
  } scan_min_t;

  typedef struct packed {
    drive_mode_t mode;
    logic        lost_valid;
    logic        lost;
  } decision_t;

endpackage

// ===== hdl/wfms_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wfms_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module wfms_cfg_regs
  import wfms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_dist_mm   <= 14'd400;
      cfg.max_range_mm     <= 16'd4000;
      cfg.base_linear_vel  <= 11'd200;
      cfg.base_angular_vel <= 11'd300;
      cfg.lost_limit       <= 8'd200;
      cfg.executing        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DETECT_DIST:  cfg.detect_dist_mm   <= cfg_data[13:0];
        REG_MAX_RANGE:    cfg.max_range_mm     <= cfg_data[15:0];
        REG_BASE_LINEAR:  cfg.base_linear_vel  <= cfg_data[10:0];
        REG_BASE_ANGULAR: cfg.base_angular_vel <= cfg_data[10:0];
        REG_LOST_LIMIT:   cfg.lost_limit       <= cfg_data[7:0];
        REG_EXECUTING:    cfg.executing        <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/wfms_region_min.sv =====
// ----------------------------------------------------------------------------
// wfms_region_min
// Sample index and running minimum of the four tracked angular regions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wfms_region_min
  import wfms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sample_req_t sample,
  input  logic [15:0] max_range_mm,
  output scan_min_t   minima
);

  logic [IDX_W-1:0] sample_index;
  logic [15:0]      min_val [4];
  logic [3:0]       seen;
  logic [3:0]       hit;
  logic [15:0]      cur [4];
  logic [15:0]      nxt [4];
  logic             scan_end;

  // region 0 right, 1 right diagonal, 2 front, 3 left diagonal; the left region is dropped
  assign hit[0] = (sample_index < RIGHT_END);
  assign hit[1] = !hit[0] && (sample_index < DIAG_RIGHT_END);
  assign hit[2] = !hit[0] && !hit[1] && (sample_index < FRONT_END);
  assign hit[3] = !hit[0] && !hit[1] && !hit[2] && (sample_index < DIAG_LEFT_END);

  // an empty region reads as the range limit, a stored minimum is held to the current limit
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (seen[k] && (min_val[k] < max_range_mm)) begin
        cur[k] = min_val[k];
      end else begin
        cur[k] = max_range_mm;
      end
      nxt[k] = (hit[k] && (sample.value < cur[k])) ? sample.value : cur[k];
    end
  end

  assign minima.right      = nxt[0];
  assign minima.diag_right = nxt[1];
  assign minima.front      = nxt[2];
  assign minima.diag_left  = nxt[3];

  assign scan_end = sample.fire && sample.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      seen         <= '0;
    end else if (sample.fire) begin
      if (sample.last) begin
        sample_index <= '0;
        seen         <= '0;
      end else begin
        if (sample_index != LAST_IDX) begin
          sample_index <= sample_index + 1'b1;
        end
        seen <= seen | hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.fire && !sample.last) begin
      for (int k = 0; k < 4; k++) begin
        if (hit[k]) begin
          min_val[k] <= nxt[k];
        end
      end
    end
  end

  `WFMS_ASSERT_NEXT(a_scan_end_index, scan_end, sample_index == '0, "index kept after scan end")
  `WFMS_ASSERT_NEXT(a_scan_end_seen, scan_end, seen == '0, "regions kept after scan end")

endmodule

// ===== hdl/wfms_mode_ctrl.sv =====
// ----------------------------------------------------------------------------
// wfms_mode_ctrl
// Drive mode decision at scan end, time-in-mode count and lost detection.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wfms_mode_ctrl
  import wfms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        decide,
  input  scan_min_t   minima,
  input  cfg_t        cfg,
  output drive_mode_t drive_state,
  output decision_t   dec
);

  logic [7:0]  time_in_mode;
  logic [16:0] d, d_p100, d_p50, d_m100;
  logic [16:0] r, fr, f, fl;
  logic        obstacle;
  logic        mode_change;
  drive_mode_t mode_next;

  assign d      = {3'b000, cfg.detect_dist_mm};
  assign d_p100 = d + 17'd100;
  assign d_p50  = d + 17'd50;
  assign d_m100 = d - 17'd100;

  assign r  = {1'b0, minima.right};
  assign fr = {1'b0, minima.diag_right};
  assign f  = {1'b0, minima.front};
  assign fl = {1'b0, minima.diag_left};

  assign obstacle = (fr < d) || (f <= d) || ((d >= 17'd100) && (fl < d_m100));

  always_comb begin
    if (obstacle) begin
      mode_next = ((f > d_p100) && (r > 17'd300)) ? MODE_TURN_LEFT : MODE_TURN_ONLY;
    end else if (r > d) begin
      mode_next = MODE_FIND;
    end else if ((r > 17'd300) && (r < d_p50)) begin
      mode_next = MODE_FOLLOW;
    end else begin
      mode_next = MODE_TURN_ONLY;
    end
  end

  assign mode_change = decide && (mode_next != drive_state);

  always_comb begin
    dec.mode       = mode_next;
    dec.lost_valid = (mode_next == drive_state) && cfg.executing;
    dec.lost       = dec.lost_valid && (drive_state == MODE_FIND)
                     && (time_in_mode > cfg.lost_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_state  <= MODE_TURN_ONLY;
      time_in_mode <= '0;
    end else if (decide) begin
      if (mode_next != drive_state) begin
        drive_state  <= mode_next;
        time_in_mode <= '0;
      end else if (cfg.executing && !dec.lost && (time_in_mode != 8'hFF)) begin
        time_in_mode <= time_in_mode + 1'b1;
      end
    end
  end

  `WFMS_ASSERT_NEXT(a_change_clears_time, mode_change, time_in_mode == '0, "time in mode kept")

endmodule

// ===== hdl/wall_follow_mode_selector_unit.sv =====
// ----------------------------------------------------------------------------
// wall_follow_mode_selector_unit
// Wall-following drive mode selector fed by a laser scan, one range sample
// per request, with control ticks that return the velocity command.
//
// One request is accepted every cycle while the result side is not stalled.
// Each request goes through an input register (range clamp) and then the
// region-minimum, mode-decision and velocity logic into the result register,
// and a stall on the result side can hold the request in the input register.
// Range samples other than the last of a scan give no result; the
// last sample gives the scan decision and a control tick gives the velocity
// command. A stalled result holds both stages and in turn stalls the input.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wall_follow_mode_selector_unit
  import wfms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [15:0]           range_mm,
  input  logic                  last_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  kind,
  output logic [1:0]            drive_mode,
  output logic                  lost_valid,
  output logic                  lost,
  output logic [10:0]           linear_cmd,
  output logic signed [12:0]    angular_cmd
);

  cfg_t        cfg;
  sample_req_t sample;
  scan_min_t   minima;
  drive_mode_t drive_state;
  decision_t   dec;

  logic        s1_valid;
  logic        s1_mode;
  logic        s1_last;
  logic [15:0] s1_value;
  logic        advance;
  logic        s2_fire;
  logic        has_result;
  logic [10:0] lin;
  logic signed [12:0] ang;
  logic [11:0] find_sum;
  logic        tick_out;
  logic        dec_out;
  logic        lost_out;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign s2_fire  = s1_valid && advance;
  assign has_result = s1_mode || s1_last;

  // input stage, range clamped here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode  <= mode;
      s1_last  <= last_sample;
      s1_value <= (range_mm > cfg.max_range_mm) ? cfg.max_range_mm : range_mm;
    end
  end

  wfms_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign sample.fire  = s2_fire && !s1_mode;
  assign sample.last  = s1_last;
  assign sample.value = s1_value;

  wfms_region_min u_region (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .max_range_mm (cfg.max_range_mm),
    .minima       (minima)
  );

  wfms_mode_ctrl u_mode (
    .clk         (clk),
    .rst         (rst),
    .decide      (sample.fire && s1_last),
    .minima      (minima),
    .cfg         (cfg),
    .drive_state (drive_state),
    .dec         (dec)
  );

  assign find_sum = {1'b0, cfg.base_angular_vel} + {2'b00, cfg.base_linear_vel[10:1]};

  // velocity command for the current drive mode
  always_comb begin
    lin = '0;
    ang = '0;
    if (cfg.executing) begin
      unique case (drive_state)
        MODE_FIND: begin
          if (cfg.base_angular_vel > 11'd300) begin
            lin = 11'd150;
            ang = -13'sd600;
          end else begin
            lin = {1'b0, cfg.base_linear_vel[10:1]};
            ang = -$signed({1'b0, find_sum});
          end
        end
        MODE_TURN_LEFT: begin
          lin = 11'd100;
          ang = (cfg.base_angular_vel > 11'd300) ? 13'sd300
                : $signed({2'b00, cfg.base_angular_vel});
        end
        MODE_FOLLOW: begin
          lin = (cfg.base_linear_vel > 11'd300) ? 11'd400 : cfg.base_linear_vel;
          ang = '0;
        end
        MODE_TURN_ONLY: begin
          lin = '0;
          ang = $signed({2'b00, cfg.base_angular_vel});
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_fire && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && has_result) begin
      kind <= s1_mode;
      if (s1_mode) begin
        drive_mode  <= drive_state;
        lost_valid  <= 1'b0;
        lost        <= 1'b0;
        linear_cmd  <= lin;
        angular_cmd <= ang;
      end else begin
        drive_mode  <= dec.mode;
        lost_valid  <= dec.lost_valid;
        lost        <= dec.lost;
        linear_cmd  <= '0;
        angular_cmd <= '0;
      end
    end
  end

  assign tick_out = out_valid && kind;
  assign dec_out  = out_valid && !kind;
  assign lost_out = out_valid && lost;

  `WFMS_ASSERT_IMPL(a_tick_no_lost, tick_out, !lost_valid && !lost, "lost on velocity result")
  `WFMS_ASSERT_IMPL(a_decision_zero_lin, dec_out, linear_cmd == '0, "linear on decision")
  `WFMS_ASSERT_IMPL(a_decision_zero_ang, dec_out, angular_cmd == '0, "angular on decision")
  `WFMS_ASSERT_IMPL(a_lost_valid, lost_out, lost_valid, "lost without valid")
  `WFMS_ASSERT_IMPL(a_lost_in_find, lost_out, drive_mode == MODE_FIND, "lost outside find")

endmodule
